// ===== design/bts_pkg.sv =====
// Shared types, codes and reset values for the best-target selector.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int AreaW    = 24;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_CLASS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SCORE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLEND_WEIGHT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SUSTAIN_TICKS = 3'd3;

  localparam logic [7:0]  TARGET_CLASS_RST  = 8'd0;
  localparam logic [15:0] MIN_SCORE_RST     = 16'd32768;
  localparam logic [8:0]  BLEND_WEIGHT_RST  = 9'd128;
  localparam logic [15:0] SUSTAIN_TICKS_RST = 16'd8;
  localparam logic [15:0] AGE_MAX           = 16'hFFFF;

  localparam logic REQ_HYPOTHESIS = 1'b0;
  localparam logic REQ_TICK       = 1'b1;
  localparam logic KIND_TARGET    = 1'b0;
  localparam logic KIND_RESEND    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         class_code;
    logic [15:0]        score;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic signed [15:0] bearing_horiz;
    logic signed [15:0] bearing_vert;
    logic [15:0]        centre_x;
    logic [15:0]        centre_y;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic               emit_kind;
    logic signed [15:0] out_bearing_horiz;
    logic signed [15:0] out_bearing_vert;
    logic [15:0]        out_centre_x;
    logic [15:0]        out_centre_y;
    logic [11:0]        out_box_width;
    logic [11:0]        out_box_height;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] bh;
    logic signed [15:0] bv;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [11:0]        w;
    logic [11:0]        h;
  } track_t;

  typedef struct packed {
    logic   found;
    track_t track;
  } pick_t;

endpackage

// ===== design/bts_in_stage.sv =====
// Input register: holds one transaction and its box area.
`timescale 1ns / 1ps

module bts_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bts_pkg::in_item_t   in_data_i,
  input  logic                advance_i,
  output logic                item_valid_o,
  output bts_pkg::in_item_t   item_o,
  output logic [bts_pkg::AreaW-1:0] area_o
);

  logic                      valid_q;
  bts_pkg::in_item_t         item_q;
  logic [bts_pkg::AreaW-1:0] area_q;

  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // area is multiplied here so the compare stage has no multiplier in front
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
      area_q <= {12'd0, in_data_i.box_width} * {12'd0, in_data_i.box_height};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign area_o       = area_q;

endmodule

// ===== design/bts_cand.sv =====
// Per-frame candidate: keeps the largest qualifying box seen so far.
`timescale 1ns / 1ps

module bts_cand (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  bts_pkg::in_item_t         item_i,
  input  logic [bts_pkg::AreaW-1:0] area_i,
  input  logic [7:0]                target_class_i,
  input  logic [15:0]               min_score_i,
  output bts_pkg::pick_t            pick_o
);

  logic                      cand_valid_q, cand_valid_d;
  logic [bts_pkg::AreaW-1:0] cand_area_q, cand_area_d;
  bts_pkg::track_t           cand_q;
  bts_pkg::track_t           item_track;
  logic                      hypo;
  logic                      take;

  assign hypo = fire_i && (item_i.req_type == bts_pkg::REQ_HYPOTHESIS);

  // first qualifying hypothesis is kept even at zero area
  assign take = (item_i.class_code == target_class_i) && (item_i.score >= min_score_i) &&
                (!cand_valid_q || (area_i > cand_area_q));

  always_comb begin
    item_track.bh = item_i.bearing_horiz;
    item_track.bv = item_i.bearing_vert;
    item_track.cx = item_i.centre_x;
    item_track.cy = item_i.centre_y;
    item_track.w  = item_i.box_width;
    item_track.h  = item_i.box_height;
  end

  always_comb begin
    cand_valid_d = cand_valid_q;
    cand_area_d  = cand_area_q;
    if (hypo) begin
      if (item_i.frame_end) begin
        cand_valid_d = 1'b0;
        cand_area_d  = '0;
      end else if (take) begin
        cand_valid_d = 1'b1;
        cand_area_d  = area_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
      cand_area_q  <= '0;
    end else begin
      cand_valid_q <= cand_valid_d;
      cand_area_q  <= cand_area_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hypo && take && !item_i.frame_end) begin
      cand_q <= item_track;
    end
  end

  // winner as seen after this transaction is considered
  assign pick_o.found = take || cand_valid_q;
  assign pick_o.track = take ? item_track : cand_q;

endmodule

// ===== design/bts_blend.sv =====
// Exponential smoothing of bearing and centre towards the new winner.
`timescale 1ns / 1ps

module bts_blend (
  input  bts_pkg::track_t prev_i,
  input  bts_pkg::track_t cur_i,
  input  logic [8:0]      weight_i,
  output bts_pkg::track_t mix_o
);

  logic [8:0] alpha;

  // prev + floor((a * (cur - prev) + 128) / 256)
  function automatic logic [15:0] mix(input logic signed [16:0] prev,
                                      input logic signed [16:0] cur,
                                      input logic [8:0] a);
    logic signed [17:0] diff;
    logic signed [27:0] prod;
    logic signed [19:0] sum;
    diff = {cur[16], cur} - {prev[16], prev};
    prod = diff * $signed({1'b0, a});
    prod = prod + 28'sd128;
    sum  = {{3{prev[16]}}, prev} + prod[27:8];
    return sum[15:0];
  endfunction

  assign alpha = weight_i[8] ? 9'd256 : weight_i;

  always_comb begin
    mix_o    = cur_i;
    mix_o.bh = mix({prev_i.bh[15], prev_i.bh}, {cur_i.bh[15], cur_i.bh}, alpha);
    mix_o.bv = mix({prev_i.bv[15], prev_i.bv}, {cur_i.bv[15], cur_i.bv}, alpha);
    mix_o.cx = mix({1'b0, prev_i.cx}, {1'b0, cur_i.cx}, alpha);
    mix_o.cy = mix({1'b0, prev_i.cy}, {1'b0, cur_i.cy}, alpha);
  end

endmodule

// ===== design/best_target_select_and_smooth_top.sv =====
// Top level of the best-target selector with smoothing and heartbeat re-emission.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle while in_stall_o is low, hypotheses and
// ticks alike. Each passes the input register (where the box area is formed)
// and then the compare, blend and target-update logic, which loads its result,
// if any, into the result register. in_stall_o rises only while the input
// register is full and the result register holds a result that is stalled.
// Configuration is taken through cfg_we_i at any edge and should be written
// while no transaction is in flight.
module best_target_select_and_smooth_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bts_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bts_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bts_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [7:0]  target_class_q;
  logic [15:0] min_score_q;
  logic [8:0]  blend_weight_q;
  logic [15:0] sustain_ticks_q;

  logic                      advance;
  logic                      item_valid;
  bts_pkg::in_item_t         item;
  logic [bts_pkg::AreaW-1:0] area;
  logic                      fire;
  logic                      is_tick;
  bts_pkg::pick_t            pick;
  bts_pkg::track_t           blended;
  bts_pkg::track_t           new_track;

  logic               target_valid_q, target_valid_d;
  bts_pkg::track_t    target_q;
  logic [15:0]        age_q, age_d;
  logic               new_target;
  logic               emit;
  logic               out_valid_q;
  bts_pkg::out_item_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_class_q  <= bts_pkg::TARGET_CLASS_RST;
      min_score_q     <= bts_pkg::MIN_SCORE_RST;
      blend_weight_q  <= bts_pkg::BLEND_WEIGHT_RST;
      sustain_ticks_q <= bts_pkg::SUSTAIN_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bts_pkg::CFG_TARGET_CLASS:  target_class_q  <= cfg_data_i[7:0];
        bts_pkg::CFG_MIN_SCORE:     min_score_q     <= cfg_data_i;
        bts_pkg::CFG_BLEND_WEIGHT:  blend_weight_q  <= cfg_data_i[8:0];
        bts_pkg::CFG_SUSTAIN_TICKS: sustain_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid_q || !out_stall_i;

  bts_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item),
    .area_o       (area)
  );

  assign fire    = item_valid && advance;
  assign is_tick = (item.req_type == bts_pkg::REQ_TICK);

  bts_cand u_cand (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (item),
    .area_i         (area),
    .target_class_i (target_class_q),
    .min_score_i    (min_score_q),
    .pick_o         (pick)
  );

  bts_blend u_blend (
    .prev_i   (target_q),
    .cur_i    (pick.track),
    .weight_i (blend_weight_q),
    .mix_o    (blended)
  );

  // first target ever passes straight through
  assign new_track  = target_valid_q ? blended : pick.track;
  assign new_target = fire && !is_tick && item.frame_end && pick.found;

  always_comb begin
    target_valid_d = target_valid_q;
    age_d          = age_q;
    emit           = 1'b0;
    out_d          = out_q;
    if (new_target) begin
      target_valid_d          = 1'b1;
      age_d                   = '0;
      emit                    = 1'b1;
      out_d.emit_kind         = bts_pkg::KIND_TARGET;
      out_d.out_bearing_horiz = new_track.bh;
      out_d.out_bearing_vert  = new_track.bv;
      out_d.out_centre_x      = new_track.cx;
      out_d.out_centre_y      = new_track.cy;
      out_d.out_box_width     = new_track.w;
      out_d.out_box_height    = new_track.h;
    end else if (fire && is_tick) begin
      // re-emit on the age before the increment
      emit = target_valid_q && (age_q <= sustain_ticks_q);
      if (age_q != bts_pkg::AGE_MAX) begin
        age_d = age_q + 16'd1;
      end
      out_d.emit_kind         = bts_pkg::KIND_RESEND;
      out_d.out_bearing_horiz = target_q.bh;
      out_d.out_bearing_vert  = target_q.bv;
      out_d.out_centre_x      = target_q.cx;
      out_d.out_centre_y      = target_q.cy;
      out_d.out_box_width     = target_q.w;
      out_d.out_box_height    = target_q.h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_valid_q <= 1'b0;
      age_q          <= bts_pkg::AGE_MAX;
      out_valid_q    <= 1'b0;
    end else begin
      target_valid_q <= target_valid_d;
      age_q          <= age_d;
      if (advance) begin
        out_valid_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_target) begin
      target_q <= new_track;
    end
    if (fire && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_target_after_new : assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_target |=> (target_valid_q && age_q == '0 && out_valid_q))
    else $error("new target not recorded");

  a_kind_target_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.emit_kind == bts_pkg::KIND_TARGET) |-> target_valid_q)
    else $error("target result without stored target");

  a_age_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_tick && age_q == bts_pkg::AGE_MAX) |=> age_q == bts_pkg::AGE_MAX)
    else $error("age counter wrapped");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  a_hold_age_on_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(age_q))
    else $error("age moved without a transaction");
`endif

endmodule
